// File: hdl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// Used by every module of the block; depends on nothing else.
package cau_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DW         = 32;
    localparam int PW         = 2 * DW;
    localparam int QSH        = DW - FRAC_BITS;
    localparam int THR_W      = 31;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int DIV_STEPS  = DW;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
    localparam logic [DW-1:0]    POS_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]    NEG_MIN   = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic addsub;
        logic sub;
        logic mul;
        logic div;
    } cls_t;

    typedef struct packed {
        cls_t                  cls;
        logic signed [DW-1:0]  a_re;
        logic signed [DW-1:0]  a_im;
        logic signed [DW-1:0]  b_re;
        logic signed [DW-1:0]  b_im;
    } item_t;

endpackage

// File: hdl/cau_front.sv
// Front end: accepts items from the input queue interface and classifies the operation.
// Depends on cau_pkg.
module cau_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  operation,
    input  logic signed [cau_pkg::DW-1:0] a_re,
    input  logic signed [cau_pkg::DW-1:0] a_im,
    input  logic signed [cau_pkg::DW-1:0] b_re,
    input  logic signed [cau_pkg::DW-1:0] b_im,
    output logic                        q_push,
    input  logic                        q_full,
    output cau_pkg::item_t              q_item
);
    import cau_pkg::*;

    logic  vld_reg;
    item_t item_reg;
    cls_t  cls_dec;
    logic  accept;

    always_comb
    begin
        cls_dec = '0;
        unique case (op_t'(operation))
            OP_ADD:
            begin
                cls_dec.addsub = 1'b1;
            end
            OP_SUB:
            begin
                cls_dec.addsub = 1'b1;
                cls_dec.sub    = 1'b1;
            end
            OP_MUL:
            begin
                cls_dec.mul = 1'b1;
            end
            OP_DIV:
            begin
                cls_dec.div = 1'b1;
            end
            default:
            begin
                cls_dec = '0;
            end
        endcase
    end

    assign full   = vld_reg && q_full;
    assign accept = push && !full;
    assign q_push = vld_reg && !q_full;
    assign q_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            vld_reg <= 1'b1;
        end
        else if (q_push)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cls  <= cls_dec;
            item_reg.a_re <= a_re;
            item_reg.a_im <= a_im;
            item_reg.b_re <= b_re;
            item_reg.b_im <= b_im;
        end
    end

endmodule

// File: hdl/cau_fifo.sv
// Short queue between front end and arithmetic back end.
// Depends on cau_pkg.
module cau_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    output logic           full,
    input  cau_pkg::item_t wr_item,
    input  logic           rd,
    output logic           empty,
    output cau_pkg::item_t rd_item
);
    import cau_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: hdl/cau_back.sv
// Back end: product, combine, sign-magnitude, pipelined restoring divider, saturation.
// Depends on cau_pkg; fed from cau_fifo.
module cau_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  cau_pkg::item_t                 q_item,
    output logic                           q_pop,
    input  logic [cau_pkg::THR_W-1:0]      thr,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [cau_pkg::DW-1:0]  res_re,
    output logic signed [cau_pkg::DW-1:0]  res_im,
    output logic                           overflow,
    output logic                           div_by_zero,
    output logic                           is_zero
);
    import cau_pkg::*;

    typedef struct packed {
        logic          neg;
        logic          big;
        logic [PW-1:0] rem;
        logic [DW-1:0] nbits;
        logic [DW-1:0] q;
    } lane_t;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          ovf;
        logic [DW-1:0] mag;
    } sat_t;

    function automatic lane_t lane_init(logic neg, logic [PW-1:0] mag, logic [PW-1:0] den,
                                        logic run, logic dz);
        lane_t l;
        l = '0;
        if (dz)
        begin
            l = '0;
        end
        else if (run)
        begin
            l.neg   = neg;
            l.big   = ({{QSH{1'b0}}, mag} >= {den, {QSH{1'b0}}});
            l.rem   = mag >> QSH;
            l.nbits = {mag[QSH-1:0], {FRAC_BITS{1'b0}}};
        end
        else
        begin
            l.neg = neg;
            l.big = |mag[PW-1:DW];
            l.q   = mag[DW-1:0];
        end
        return l;
    endfunction

    function automatic lane_t div_step(lane_t l, logic [PW-1:0] den, logic run);
        lane_t      r;
        logic [PW:0] r2;
        logic       ge;
        r  = l;
        r2 = {l.rem, l.nbits[DW-1]};
        ge = (r2 >= {1'b0, den});
        if (run)
        begin
            if (ge)
            begin
                r2 = r2 - {1'b0, den};
            end
            r.rem   = r2[PW-1:0];
            r.nbits = {l.nbits[DW-2:0], 1'b0};
            r.q     = {l.q[DW-2:0], ge};
        end
        return r;
    endfunction

    function automatic sat_t saturate(lane_t l);
        sat_t s;
        s.ovf = 1'b0;
        if (!l.neg)
        begin
            if (l.big || l.q[DW-1])
            begin
                s.val = POS_MAX;
                s.mag = POS_MAX;
                s.ovf = 1'b1;
            end
            else
            begin
                s.val = l.q;
                s.mag = l.q;
            end
        end
        else
        begin
            if (l.big || (l.q > NEG_MIN))
            begin
                s.val = NEG_MIN;
                s.mag = NEG_MIN;
                s.ovf = 1'b1;
            end
            else
            begin
                s.val = -l.q;
                s.mag = l.q;
            end
        end
        return s;
    endfunction

    logic en;

    // product stage
    logic                 s1_vld_reg;
    cls_t                 s1_cls_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_br_reg, p_bi_reg;
    logic signed [DW:0]   sum_re_reg, sum_im_reg;

    // combine stage
    logic                 s2_vld_reg;
    cls_t                 s2_cls_reg;
    logic signed [PW:0]   num_re_reg, num_im_reg;
    logic [PW-1:0]        s2_den_reg;
    logic signed [PW:0]   num_re_next, num_im_next;

    // sign-magnitude stage
    logic                 s3_vld_reg;
    logic                 s3_run_reg, s3_dz_reg;
    logic                 neg_re_reg, neg_im_reg;
    logic [PW-1:0]        mag_re_reg, mag_im_reg;
    logic [PW-1:0]        s3_den_reg;
    logic [PW:0]          abs_re, abs_im;
    logic [PW-1:0]        mag_re_next, mag_im_next;

    // divider stages, index 0 is the setup stage
    logic                 st_vld_reg [DIV_STEPS+1];
    logic                 st_run_reg [DIV_STEPS+1];
    logic                 st_dz_reg  [DIV_STEPS+1];
    logic [PW-1:0]        st_den_reg [DIV_STEPS+1];
    lane_t                st_re_reg  [DIV_STEPS+1];
    lane_t                st_im_reg  [DIV_STEPS+1];

    // result register
    logic                 out_vld_reg;
    logic [DW-1:0]        res_re_reg, res_im_reg;
    logic                 ovf_reg, dz_reg, zero_reg;
    sat_t                 sat_re, sat_im;

    assign en    = !out_vld_reg || pop;
    assign q_pop = en && !q_empty;

    always_comb
    begin
        num_re_next = '0;
        num_im_next = '0;
        if (s1_cls_reg.mul)
        begin
            num_re_next = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
            num_im_next = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
        end
        else if (s1_cls_reg.div)
        begin
            num_re_next = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
            num_im_next = (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
        end
        else if (s1_cls_reg.addsub)
        begin
            num_re_next = (PW+1)'(sum_re_reg);
            num_im_next = (PW+1)'(sum_im_reg);
        end
    end

    always_comb
    begin
        abs_re      = num_re_reg[PW] ? -num_re_reg : num_re_reg;
        abs_im      = num_im_reg[PW] ? -num_im_reg : num_im_reg;
        mag_re_next = abs_re[PW-1:0];
        mag_im_next = abs_im[PW-1:0];
        // drop the extra fraction bits of a product
        if (s2_cls_reg.mul)
        begin
            mag_re_next = abs_re[PW-1:0] >> FRAC_BITS;
            mag_im_next = abs_im[PW-1:0] >> FRAC_BITS;
        end
    end

    assign sat_re = saturate(st_re_reg[DIV_STEPS]);
    assign sat_im = saturate(st_im_reg[DIV_STEPS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                st_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg    <= !q_empty;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            st_vld_reg[0] <= s3_vld_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                st_vld_reg[k+1] <= st_vld_reg[k];
            end
            out_vld_reg <= st_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cls_reg <= q_item.cls;
            p_rr_reg   <= PW'(q_item.a_re) * PW'(q_item.b_re);
            p_ii_reg   <= PW'(q_item.a_im) * PW'(q_item.b_im);
            p_ri_reg   <= PW'(q_item.a_re) * PW'(q_item.b_im);
            p_ir_reg   <= PW'(q_item.a_im) * PW'(q_item.b_re);
            p_br_reg   <= PW'(q_item.b_re) * PW'(q_item.b_re);
            p_bi_reg   <= PW'(q_item.b_im) * PW'(q_item.b_im);
            if (q_item.cls.sub)
            begin
                sum_re_reg <= (DW+1)'(q_item.a_re) - (DW+1)'(q_item.b_re);
                sum_im_reg <= (DW+1)'(q_item.a_im) - (DW+1)'(q_item.b_im);
            end
            else
            begin
                sum_re_reg <= (DW+1)'(q_item.a_re) + (DW+1)'(q_item.b_re);
                sum_im_reg <= (DW+1)'(q_item.a_im) + (DW+1)'(q_item.b_im);
            end

            s2_cls_reg <= s1_cls_reg;
            num_re_reg <= num_re_next;
            num_im_reg <= num_im_next;
            s2_den_reg <= unsigned'(p_br_reg) + unsigned'(p_bi_reg);

            s3_dz_reg  <= s2_cls_reg.div && (s2_den_reg == '0);
            s3_run_reg <= s2_cls_reg.div && (s2_den_reg != '0);
            neg_re_reg <= num_re_reg[PW];
            neg_im_reg <= num_im_reg[PW];
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            s3_den_reg <= s2_den_reg;

            st_run_reg[0] <= s3_run_reg;
            st_dz_reg[0]  <= s3_dz_reg;
            st_den_reg[0] <= s3_den_reg;
            st_re_reg[0]  <= lane_init(neg_re_reg, mag_re_reg, s3_den_reg, s3_run_reg, s3_dz_reg);
            st_im_reg[0]  <= lane_init(neg_im_reg, mag_im_reg, s3_den_reg, s3_run_reg, s3_dz_reg);

            // one quotient bit per stage
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                st_run_reg[k+1] <= st_run_reg[k];
                st_dz_reg[k+1]  <= st_dz_reg[k];
                st_den_reg[k+1] <= st_den_reg[k];
                st_re_reg[k+1]  <= div_step(st_re_reg[k], st_den_reg[k], st_run_reg[k]);
                st_im_reg[k+1]  <= div_step(st_im_reg[k], st_den_reg[k], st_run_reg[k]);
            end

            res_re_reg <= sat_re.val;
            res_im_reg <= sat_im.val;
            ovf_reg    <= sat_re.ovf || sat_im.ovf;
            dz_reg     <= st_dz_reg[DIV_STEPS];
            zero_reg   <= (sat_re.mag < {1'b0, thr}) && (sat_im.mag < {1'b0, thr});
        end
    end

    assign empty       = !out_vld_reg;
    assign res_re      = signed'(res_re_reg);
    assign res_im      = signed'(res_im_reg);
    assign overflow    = ovf_reg;
    assign div_by_zero = dz_reg;
    assign is_zero     = zero_reg;

endmodule

// File: hdl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: threshold register, front end, queue, back end.
// Depends on cau_pkg, cau_front, cau_fifo and cau_back.
//
// Usage:
//   Input channel: drive operation and a_re/a_im/b_re/b_im with push; the
//   item transfers at a clock edge with push high and full low.
//   Result channel: while empty is low the oldest result sits on res_re,
//   res_im, overflow, div_by_zero and is_zero; it transfers at an edge with
//   pop high. Operands and results are signed Q16.16.
//   Config channel: cfg_data (zero_threshold) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Every operation takes the same path through the pipeline, set by the
//   32-stage restoring divider, one quotient bit per stage. Throughput: one
//   item per cycle while the receiver does not stall.
//   Reset: all pipeline stages and the queue empty out, zero_threshold is 1.
//   When the receiver stalls, the whole back end holds; the four-entry queue
//   and the front register absorb input before full rises.
module complex_arithmetic_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      operation,
    input  logic signed [cau_pkg::DW-1:0]   a_re,
    input  logic signed [cau_pkg::DW-1:0]   a_im,
    input  logic signed [cau_pkg::DW-1:0]   b_re,
    input  logic signed [cau_pkg::DW-1:0]   b_im,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [cau_pkg::DW-1:0]   res_re,
    output logic signed [cau_pkg::DW-1:0]   res_im,
    output logic                            overflow,
    output logic                            div_by_zero,
    output logic                            is_zero,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cau_pkg::THR_W-1:0]       cfg_data
);
    import cau_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             q_push, q_full, q_pop, q_empty;
    item_t            q_wr_item, q_rd_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_item    (q_wr_item)
    );

    cau_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .full    (q_full),
        .wr_item (q_wr_item),
        .rd      (q_pop),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    cau_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_rd_item),
        .q_pop       (q_pop),
        .thr         (thr_reg),
        .empty       (empty),
        .pop         (pop),
        .res_re      (res_re),
        .res_im      (res_im),
        .overflow    (overflow),
        .div_by_zero (div_by_zero),
        .is_zero     (is_zero)
    );

    // a zero divisor never saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(overflow && div_by_zero))
        else $error("overflow together with div_by_zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && div_by_zero) |-> (res_re == '0 && res_im == '0))
        else $error("nonzero result on divide by zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && thr_reg == '0) |-> !is_zero)
        else $error("is_zero with zero threshold");

    // the back end must not pull from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

endmodule
